// ----- rtl/ibag_pkg.sv -----
// Shared types and constants for the image border address generator.
// No dependencies; every other file in rtl imports this package.
`default_nettype none

package ibag_pkg;

   localparam int COORD_W   = 16;
   localparam int DIM_REG_W = 13;
   localparam int INDEX_W   = 24;
   localparam int DATA_W    = 32;
   localparam int ADDR_W    = 4;
   // Input register, one cell per magnitude bit, map stage, output register.
   localparam int LATENCY   = COORD_W + 3;

   typedef enum logic [1:0] {
      MODE_PERIODIC  = 2'd0,
      MODE_CONSTANT  = 2'd1,
      MODE_NEAREST   = 2'd2,
      MODE_SYMMETRIC = 2'd3
   } border_mode_type;

   typedef enum logic [1:0] {
      REG_IMAGE_WIDTH  = 2'd0,
      REG_IMAGE_HEIGHT = 2'd1,
      REG_BORDER_MODE  = 2'd2,
      REG_CONST_VALUE  = 2'd3
   } reg_index_type;

   // One coordinate travelling down the remainder chain.
   typedef struct packed {
      logic                       neg;
      logic signed [COORD_W-1:0]  orig;
      logic [COORD_W-1:0]         mag;
   } lane_type;

endpackage

`default_nettype wire

// ----- rtl/ibag_mod_cell.sv -----
// One cell of the restoring remainder chain: consumes one magnitude bit per
// coordinate and hands the partial remainder to the next cell. Uses ibag_pkg.
`default_nettype none

module ibag_mod_cell
   import ibag_pkg::*;
#(
   parameter int PW = 14
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          up_valid,
   input  wire lane_type      up_col,
   input  wire lane_type      up_row,
   input  wire logic [PW-1:0] up_col_rem,
   input  wire logic [PW-1:0] up_row_rem,
   input  wire logic [PW-1:0] col_div,
   input  wire logic [PW-1:0] row_div,
   output logic               down_valid,
   output lane_type           down_col,
   output lane_type           down_row,
   output logic [PW-1:0]      down_col_rem,
   output logic [PW-1:0]      down_row_rem
);

   logic            valid_ff;
   lane_type        col_ff, col_in;
   lane_type        row_ff, row_in;
   logic [PW-1:0]   col_rem_ff, col_rem_in;
   logic [PW-1:0]   row_rem_ff, row_rem_in;
   logic [PW:0]     col_trial, row_trial;
   logic [PW:0]     col_sub, row_sub;

   // Shift the next magnitude bit into the remainder and subtract if it fits.
   assign col_trial = {up_col_rem, up_col.mag[COORD_W-1]};
   assign row_trial = {up_row_rem, up_row.mag[COORD_W-1]};
   assign col_sub   = col_trial - {1'b0, col_div};
   assign row_sub   = row_trial - {1'b0, row_div};

   always_comb begin
      col_rem_in = (col_trial >= {1'b0, col_div}) ? col_sub[PW-1:0] : col_trial[PW-1:0];
      row_rem_in = (row_trial >= {1'b0, row_div}) ? row_sub[PW-1:0] : row_trial[PW-1:0];
      col_in      = up_col;
      col_in.mag  = {up_col.mag[COORD_W-2:0], 1'b0};
      row_in      = up_row;
      row_in.mag  = {up_row.mag[COORD_W-2:0], 1'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      col_ff     <= col_in;
      row_ff     <= row_in;
      col_rem_ff <= col_rem_in;
      row_rem_ff <= row_rem_in;
   end

   assign down_valid   = valid_ff;
   assign down_col     = col_ff;
   assign down_row     = row_ff;
   assign down_col_rem = col_rem_ff;
   assign down_row_rem = row_rem_ff;

endmodule

`default_nettype wire

// ----- rtl/ibag_coord_map.sv -----
// Maps one coordinate into the image by border mode, using the remainder
// produced by the cell chain. Combinational; uses ibag_pkg.
`default_nettype none

module ibag_coord_map
   import ibag_pkg::*;
#(
   parameter int DW = 13,
   parameter int PW = 14
) (
   input  wire border_mode_type mode,
   input  wire lane_type        lane,
   input  wire logic [PW-1:0]   rem,
   input  wire logic [PW-1:0]   div,
   input  wire logic [DW-1:0]   dim,
   output logic [DW-1:0]        coord,
   output logic                 outside
);

   logic [PW-1:0]        pmod;
   logic [PW-1:0]        mirrored;
   logic signed [31:0]   orig_wide;
   logic signed [31:0]   dim_wide;
   logic                 below, above;
   logic [DW-1:0]        clamped;

   assign orig_wide = $signed({{(32-COORD_W){lane.orig[COORD_W-1]}}, lane.orig});
   assign dim_wide  = $signed(32'(dim));
   assign below     = orig_wide < 0;
   assign above     = orig_wide >= dim_wide;
   assign outside   = below || above;

   always_comb begin
      // A negative input with a nonzero remainder folds back from the divisor.
      pmod = (lane.neg && (rem != '0)) ? (div - rem) : rem;
      if (pmod >= {1'b0, dim}) begin
         mirrored = {dim, 1'b0} - PW'(1) - pmod;
      end else begin
         mirrored = pmod;
      end
      if (below) begin
         clamped = '0;
      end else if (above) begin
         clamped = dim - DW'(1);
      end else begin
         clamped = lane.orig[DW-1:0];
      end
      unique case (mode)
         MODE_PERIODIC:  coord = pmod[DW-1:0];
         MODE_CONSTANT:  coord = outside ? '0 : lane.orig[DW-1:0];
         MODE_NEAREST:   coord = clamped;
         MODE_SYMMETRIC: coord = mirrored[DW-1:0];
         default:        coord = '0;
      endcase
   end

endmodule

`default_nettype wire

// ----- rtl/image_border_address_gen_top.sv -----
// Top level of the image border address generator: configuration registers,
// input stage, cell chain, map stage and index multiply. Uses ibag_pkg,
// ibag_mod_cell and ibag_coord_map.
//
// Usage:
//   A coordinate pair is taken on req_col/req_row at a clock edge where start
//   is high; busy never rises, so a new pair can be given every cycle.
//   Each pair yields one beat on rsp_pixel_index, rsp_use_constant and
//   rsp_constant_bits, marked by rsp_valid for exactly one cycle. Throughput
//   is one pair per cycle. Between the accepting edge and rsp_valid lie the
//   input register, the restoring remainder chain with one cell per bit of
//   the 16-bit coordinate magnitude, the border map stage and the index
//   multiply register.
//   The receiver cannot stall; results appear in input order.
//   Configuration goes through the APB-style port (width at 0x0, height at
//   0x4, border mode at 0x8, constant at 0xC) and is written by the user only
//   while no pair is in flight, which the block does not enforce. Reset empties
//   the pipeline and sets width 1, height 1, periodic mode and a zero constant.
`default_nettype none

module image_border_address_gen_top
   import ibag_pkg::*;
#(
   parameter int MAX_DIM = 4096
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   output logic                           busy,
   input  wire logic signed [COORD_W-1:0] req_col,
   input  wire logic signed [COORD_W-1:0] req_row,
   output logic                           rsp_valid,
   output logic [INDEX_W-1:0]             rsp_pixel_index,
   output logic                           rsp_use_constant,
   output logic [DATA_W-1:0]              rsp_constant_bits,
   input  wire logic                      psel,
   input  wire logic                      penable,
   input  wire logic                      pwrite,
   input  wire logic [ADDR_W-1:0]         paddr,
   input  wire logic [DATA_W-1:0]         pwdata,
   output logic [DATA_W-1:0]              prdata,
   output logic                           pready
);

   localparam int DIM_W_RAW  = $clog2(MAX_DIM + 1);
   localparam int DIM_W      = (DIM_W_RAW < DIM_REG_W) ? DIM_W_RAW : DIM_REG_W;
   localparam int PW         = DIM_W + 1;
   localparam int PROD_W     = 2 * DIM_W + 1;
   localparam int IDX_CALC_W = (PROD_W > INDEX_W) ? PROD_W : INDEX_W;

   // Configuration registers.
   logic [DIM_REG_W-1:0] width_ff;
   logic [DIM_REG_W-1:0] height_ff;
   border_mode_type      mode_ff;
   logic [DATA_W-1:0]    const_ff;
   logic                 cfg_write;
   reg_index_type        cfg_index;

   logic [DIM_W-1:0]     eff_w, eff_h;
   logic [PW-1:0]        col_div, row_div;

   // Input stage and cell chain.
   logic                 accept;
   logic                 s0_valid_ff;
   lane_type             s0_col_ff, s0_col_in;
   lane_type             s0_row_ff, s0_row_in;
   logic                 chain_valid [0:COORD_W];
   lane_type             chain_col   [0:COORD_W];
   lane_type             chain_row   [0:COORD_W];
   logic [PW-1:0]        chain_col_rem [0:COORD_W];
   logic [PW-1:0]        chain_row_rem [0:COORD_W];

   // Map stage.
   logic [DIM_W-1:0]     map_col, map_row;
   logic                 col_outside, row_outside;
   logic                 f_valid_ff;
   logic [DIM_W-1:0]     f_col_ff, f_row_ff;
   logic                 f_flag_ff, f_flag_in;

   // Output stage.
   logic [IDX_CALC_W-1:0] idx_full;
   logic                  rsp_valid_ff;
   logic [INDEX_W-1:0]    rsp_index_ff, rsp_index_in;
   logic                  rsp_flag_ff;
   logic [DATA_W-1:0]     rsp_const_ff, rsp_const_in;

   // ---------------- configuration port ----------------
   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite && pready;
   assign cfg_index = reg_index_type'(paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DIM_REG_W'(1);
         height_ff <= DIM_REG_W'(1);
         mode_ff   <= MODE_PERIODIC;
         const_ff  <= '0;
      end else if (cfg_write) begin
         unique case (cfg_index)
            REG_IMAGE_WIDTH:  width_ff  <= pwdata[DIM_REG_W-1:0];
            REG_IMAGE_HEIGHT: height_ff <= pwdata[DIM_REG_W-1:0];
            REG_BORDER_MODE:  mode_ff   <= border_mode_type'(pwdata[1:0]);
            REG_CONST_VALUE:  const_ff  <= pwdata;
            default:          const_ff  <= const_ff;
         endcase
      end
   end

   always_comb begin
      unique case (cfg_index)
         REG_IMAGE_WIDTH:  prdata = DATA_W'(width_ff);
         REG_IMAGE_HEIGHT: prdata = DATA_W'(height_ff);
         REG_BORDER_MODE:  prdata = DATA_W'(mode_ff);
         REG_CONST_VALUE:  prdata = const_ff;
         default:          prdata = '0;
      endcase
   end

   // A zero size reads as one and a size above the limit as the limit.
   always_comb begin
      if (width_ff == '0) begin
         eff_w = DIM_W'(1);
      end else if (32'(width_ff) > 32'(MAX_DIM)) begin
         eff_w = DIM_W'(MAX_DIM);
      end else begin
         eff_w = width_ff[DIM_W-1:0];
      end
      if (height_ff == '0) begin
         eff_h = DIM_W'(1);
      end else if (32'(height_ff) > 32'(MAX_DIM)) begin
         eff_h = DIM_W'(MAX_DIM);
      end else begin
         eff_h = height_ff[DIM_W-1:0];
      end
   end

   // Mirror mode reduces modulo twice the size.
   assign col_div = (mode_ff == MODE_SYMMETRIC) ? {eff_w, 1'b0} : {1'b0, eff_w};
   assign row_div = (mode_ff == MODE_SYMMETRIC) ? {eff_h, 1'b0} : {1'b0, eff_h};

   // ---------------- input stage ----------------
   assign busy   = 1'b0;
   assign accept = start && !busy;

   always_comb begin
      s0_col_in.neg  = req_col[COORD_W-1];
      s0_col_in.orig = req_col;
      s0_col_in.mag  = req_col[COORD_W-1] ? (COORD_W'(0) - req_col) : req_col;
      s0_row_in.neg  = req_row[COORD_W-1];
      s0_row_in.orig = req_row;
      s0_row_in.mag  = req_row[COORD_W-1] ? (COORD_W'(0) - req_row) : req_row;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      s0_col_ff <= s0_col_in;
      s0_row_ff <= s0_row_in;
   end

   assign chain_valid[0]   = s0_valid_ff;
   assign chain_col[0]     = s0_col_ff;
   assign chain_row[0]     = s0_row_ff;
   assign chain_col_rem[0] = '0;
   assign chain_row_rem[0] = '0;

   // ---------------- remainder chain ----------------
   for (genvar k = 0; k < COORD_W; k++) begin : g_cell
      ibag_mod_cell #(
         .PW (PW)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .up_valid     (chain_valid[k]),
         .up_col       (chain_col[k]),
         .up_row       (chain_row[k]),
         .up_col_rem   (chain_col_rem[k]),
         .up_row_rem   (chain_row_rem[k]),
         .col_div      (col_div),
         .row_div      (row_div),
         .down_valid   (chain_valid[k+1]),
         .down_col     (chain_col[k+1]),
         .down_row     (chain_row[k+1]),
         .down_col_rem (chain_col_rem[k+1]),
         .down_row_rem (chain_row_rem[k+1])
      );
   end

   // ---------------- map stage ----------------
   ibag_coord_map #(
      .DW (DIM_W),
      .PW (PW)
   ) u_map_col (
      .mode    (mode_ff),
      .lane    (chain_col[COORD_W]),
      .rem     (chain_col_rem[COORD_W]),
      .div     (col_div),
      .dim     (eff_w),
      .coord   (map_col),
      .outside (col_outside)
   );

   ibag_coord_map #(
      .DW (DIM_W),
      .PW (PW)
   ) u_map_row (
      .mode    (mode_ff),
      .lane    (chain_row[COORD_W]),
      .rem     (chain_row_rem[COORD_W]),
      .div     (row_div),
      .dim     (eff_h),
      .coord   (map_row),
      .outside (row_outside)
   );

   assign f_flag_in = (mode_ff == MODE_CONSTANT) && (col_outside || row_outside);

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else begin
         f_valid_ff <= chain_valid[COORD_W];
      end
   end

   always_ff @(posedge clock) begin
      // An outside position in constant mode points at index zero.
      f_col_ff  <= f_flag_in ? '0 : map_col;
      f_row_ff  <= f_flag_in ? '0 : map_row;
      f_flag_ff <= f_flag_in;
   end

   // ---------------- index multiply and output ----------------
   assign idx_full     = IDX_CALC_W'(f_col_ff)
                       + IDX_CALC_W'(f_row_ff) * IDX_CALC_W'(eff_w);
   assign rsp_index_in = idx_full[INDEX_W-1:0];
   assign rsp_const_in = f_flag_ff ? const_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= f_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_index_ff <= rsp_index_in;
      rsp_flag_ff  <= f_flag_ff;
      rsp_const_ff <= rsp_const_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pixel_index   = rsp_index_ff;
   assign rsp_use_constant  = rsp_flag_ff;
   assign rsp_constant_bits = rsp_const_ff;

   // ---------------- assertions ----------------
   a_latency : assert property (@(posedge clock) disable iff (reset)
      accept |-> ##LATENCY rsp_valid)
      else $error("accepted beat did not produce a result at the expected latency");

   a_const_index : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_use_constant |-> rsp_pixel_index == '0)
      else $error("constant result carries a nonzero pixel index");

   a_const_bits : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_use_constant |-> rsp_constant_bits == '0)
      else $error("constant bits set on a result that does not use the constant");

endmodule

`default_nettype wire

// ----- verif/tb.sv -----
// Self-checking testbench for image_border_address_gen_top: drives coordinate pairs and
// register writes, predicts each index beat and compares it field by field.
// Depends on ibag_pkg and the RTL under rtl; needs nothing else.
`timescale 1ns / 100ps

module tb;
   import ibag_pkg::*;

   localparam int DIM_LIMIT      = 4096;
   localparam int PHASE_COUNT    = 13;
   localparam int PAIRS_PER_PASS = 50;
   localparam int WATCHDOG_LIMIT = 2000;

   typedef struct {
      logic [INDEX_W-1:0] pixel_index;
      logic               use_constant;
      logic [DATA_W-1:0]  constant_bits;
   } pixel_result_type;

   // Holds a copy of the registers and the index beats still owed by the block.
   class pixel_addr_scoreboard;
      pixel_result_type     owed_q[$];
      logic [DIM_REG_W-1:0] width_reg;
      logic [DIM_REG_W-1:0] height_reg;
      border_mode_type      mode_reg;
      logic [DATA_W-1:0]    const_reg;
      int                   dim_limit;
      int                   errors;
      int                   checked;
      int                   outside_hits;

      function new(int limit);
         dim_limit    = limit;
         width_reg    = 1;
         height_reg   = 1;
         mode_reg     = MODE_PERIODIC;
         const_reg    = '0;
         errors       = 0;
         checked      = 0;
         outside_hits = 0;
      endfunction

      function void set_reg(reg_index_type idx, logic [DATA_W-1:0] value);
         case (idx)
            REG_IMAGE_WIDTH:  width_reg  = value[DIM_REG_W-1:0];
            REG_IMAGE_HEIGHT: height_reg = value[DIM_REG_W-1:0];
            REG_BORDER_MODE:  mode_reg   = border_mode_type'(value[1:0]);
            REG_CONST_VALUE:  const_reg  = value;
            default: ;
         endcase
      endfunction

      // A zero size acts as one, anything above the limit as the limit.
      function int clip_dim(logic [DIM_REG_W-1:0] d);
         if (d == 0) return 1;
         if (int'(d) > dim_limit) return dim_limit;
         return int'(d);
      endfunction

      function int wrap(int n, int p);
         int m;
         m = n % p;
         return (m < 0) ? m + p : m;
      endfunction

      // Half-sample mirror: fold over a period of twice the size.
      function int fold(int n, int p);
         int m;
         m = wrap(n, 2 * p);
         if (m >= p) m = 2 * p - 1 - m;
         return m;
      endfunction

      function void note_request(logic signed [COORD_W-1:0] col,
                                 logic signed [COORD_W-1:0] row);
         int               w;
         int               h;
         int               c;
         int               r;
         longint           idx;
         pixel_result_type want;
         w                  = clip_dim(width_reg);
         h                  = clip_dim(height_reg);
         c                  = col;
         r                  = row;
         want.use_constant  = 1'b0;
         want.constant_bits = '0;
         case (mode_reg)
            MODE_PERIODIC: begin
               c = wrap(c, w);
               r = wrap(r, h);
            end
            MODE_CONSTANT: begin
               if (c < 0 || c >= w || r < 0 || r >= h) begin
                  want.use_constant  = 1'b1;
                  want.constant_bits = const_reg;
                  c = 0;
                  r = 0;
               end
            end
            MODE_NEAREST: begin
               c = (c < 0) ? 0 : ((c >= w) ? w - 1 : c);
               r = (r < 0) ? 0 : ((r >= h) ? h - 1 : r);
            end
            default: begin
               c = fold(c, w);
               r = fold(r, h);
            end
         endcase
         idx              = longint'(c) + longint'(r) * longint'(w);
         want.pixel_index = idx[INDEX_W-1:0];
         owed_q.push_back(want);
      endfunction

      function void check_result(logic [INDEX_W-1:0] pixel_index, logic use_constant,
                                 logic [DATA_W-1:0] constant_bits);
         pixel_result_type want;
         if (owed_q.size() == 0) begin
            $error("index beat with no coordinate pair outstanding: index %0d", pixel_index);
            errors++;
            return;
         end
         want = owed_q.pop_front();
         checked++;
         if (want.use_constant) outside_hits++;
         if (pixel_index !== want.pixel_index) begin
            $error("pixel_index mismatch: expected %0d, actual %0d",
                   want.pixel_index, pixel_index);
            errors++;
         end
         if (use_constant !== want.use_constant) begin
            $error("use_constant mismatch: expected %0d, actual %0d",
                   want.use_constant, use_constant);
            errors++;
         end
         if (constant_bits !== want.constant_bits) begin
            $error("constant_bits mismatch: expected %h, actual %h",
                   want.constant_bits, constant_bits);
            errors++;
         end
      endfunction

      function int pending();
         return owed_q.size();
      endfunction
   endclass

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      start = 1'b0;
   logic                      busy;
   logic signed [COORD_W-1:0] req_col = '0;
   logic signed [COORD_W-1:0] req_row = '0;
   logic                      rsp_valid;
   logic [INDEX_W-1:0]        rsp_pixel_index;
   logic                      rsp_use_constant;
   logic [DATA_W-1:0]         rsp_constant_bits;
   logic                      psel    = 1'b0;
   logic                      penable = 1'b0;
   logic                      pwrite  = 1'b0;
   logic [ADDR_W-1:0]         paddr   = '0;
   logic [DATA_W-1:0]         pwdata  = '0;
   logic [DATA_W-1:0]         prdata;
   logic                      pready;

   pixel_addr_scoreboard sb;
   int                   idle_cycles = 0;
   int                   settings_used = 0;

   image_border_address_gen_top #(
      .MAX_DIM(DIM_LIMIT)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_col(req_col),
      .req_row(req_row),
      .rsp_valid(rsp_valid),
      .rsp_pixel_index(rsp_pixel_index),
      .rsp_use_constant(rsp_use_constant),
      .rsp_constant_bits(rsp_constant_bits),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         sb.check_result(rsp_pixel_index, rsp_use_constant, rsp_constant_bits);
      end
   end

   // Ends the run if neither side moves a beat for too long.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   // Writes follow each other with psel held high; load_setting closes the transfer.
   task automatic write_reg(reg_index_type idx, logic [DATA_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= ADDR_W'({idx, 2'b00});
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      sb.set_reg(idx, value);
   endtask

   task automatic load_setting(logic [DIM_REG_W-1:0] w, logic [DIM_REG_W-1:0] h,
                               border_mode_type mode, logic [DATA_W-1:0] cval);
      write_reg(REG_IMAGE_WIDTH, DATA_W'(w));
      write_reg(REG_IMAGE_HEIGHT, DATA_W'(h));
      write_reg(REG_BORDER_MODE, DATA_W'(mode));
      write_reg(REG_CONST_VALUE, cval);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      settings_used++;
   endtask

   // The pair is noted here, at the accepting edge, so a drain check that
   // follows can never miss it.
   task automatic send_pair(logic signed [COORD_W-1:0] col, logic signed [COORD_W-1:0] row);
      start   <= 1'b1;
      req_col <= col;
      req_row <= row;
      @(posedge clock);
      while (busy) @(posedge clock);
      sb.note_request(col, row);
   endtask

   task automatic pause_sender(int cycles);
      if (cycles > 0) begin
         start <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // Anything still owed means a pair was just sent, so start is dropped here;
   // with nothing owed start is already low.
   task automatic wait_drained();
      if (sb.pending() != 0) begin
         start <= 1'b0;
         while (sb.pending() != 0) @(posedge clock);
      end
   endtask

   function automatic int gap_len();
      case ($urandom_range(0, 19))
         0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11: return 0;
         12, 13, 14, 15, 16, 17: return $urandom_range(1, 3);
         default: return $urandom_range(8, 48);
      endcase
   endfunction

   function automatic logic [DIM_REG_W-1:0] pick_dim();
      case ($urandom_range(0, 7))
         0: return DIM_REG_W'($urandom_range(0, 1));
         1: return DIM_REG_W'($urandom_range(4095, 4097));
         2: return '1;
         3: return DIM_REG_W'($urandom_range(0, (1 << DIM_REG_W) - 1));
         default: return DIM_REG_W'($urandom_range(1, 16));
      endcase
   endfunction

   // Mostly positions around the image, with full-range and edge values mixed in.
   function automatic logic signed [COORD_W-1:0] pick_coord(int dim);
      int v;
      case ($urandom_range(0, 9))
         0, 1: v = $urandom_range(0, dim - 1);
         2, 3, 4, 5: v = int'($urandom_range(0, 4 * dim)) - 2 * dim;
         6, 7: v = $urandom;
         default: begin
            case ($urandom_range(0, 6))
               0: v = -32768;
               1: v = 32767;
               2: v = -1;
               3: v = 0;
               4: v = dim - 1;
               5: v = dim;
               default: v = -dim;
            endcase
         end
      endcase
      return COORD_W'(v);
   endfunction

   initial begin
      logic [DIM_REG_W-1:0] w;
      logic [DIM_REG_W-1:0] h;
      border_mode_type      mode;
      logic [DATA_W-1:0]    cval;
      bit                   no_gaps;
      sb = new(DIM_LIMIT);
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Small image, every mode, edge and extreme coordinates back to back.
      for (int m = 0; m < 4; m++) begin
         wait_drained();
         load_setting(5, 3, border_mode_type'(2'(m)), $urandom);
         send_pair(0, 0);
         send_pair(-1, -1);
         send_pair(32767, -32768);
         send_pair(-32768, 32767);
         send_pair(4, 2);
         send_pair(5, 3);
      end

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0: begin w = 4096; h = 4096; end
            1: begin w = 0;    h = 8191; end
            2: begin w = 8191; h = 0;    end
            3: begin w = 1;    h = 1;    end
            4: begin w = 4097; h = 2;    end
            default: begin w = pick_dim(); h = pick_dim(); end
         endcase
         if (phase < 8) mode = border_mode_type'(2'(phase % 4));
         else mode = border_mode_type'(2'($urandom_range(0, 3)));
         if (phase == 1) cval = '1;
         else if (phase == 2) cval = '0;
         else cval = $urandom;
         wait_drained();
         load_setting(w, h, mode, cval);
         no_gaps = ($urandom_range(0, 3) == 0);
         for (int k = 0; k < PAIRS_PER_PASS; k++) begin
            // Now and then the sender holds off until the pipeline is empty.
            if ((phase == 5 && k == 25) || $urandom_range(0, 63) == 0) wait_drained();
            else if (!no_gaps) pause_sender(gap_len());
            send_pair(pick_coord(sb.clip_dim(w)), pick_coord(sb.clip_dim(h)));
         end
      end

      wait_drained();
      repeat (LATENCY + 4) @(posedge clock);
      $display("Checked %0d index beats over %0d register settings in all four border modes.",
               sb.checked, settings_used);
      $display("Constant mode flagged %0d positions outside the image.", sb.outside_hits);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
